FILE: design/pst_pkg.sv
`timescale 1ns / 1ps

package pst_pkg;

    localparam int GENERIC_SLOTS_DEFAULT   = 8;
    localparam int WEB_AUDIO_SLOTS_DEFAULT = 8;

    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int ID_W       = 31;
    localparam int COUNT_W    = 4;
    localparam int IDX_W      = COUNT_W;
    localparam int BYTES_W    = 24;
    localparam int VA_W       = BYTES_W + 1;
    localparam int GSIZE_W    = BYTES_W + 2;
    localparam int OFFSET_W   = 32;
    localparam int LEN_W      = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_MAP,
        CMD_UNMAP,
        CMD_OFFSET,
        CMD_LENGTH
    } t_cmd;

    localparam logic [KIND_W-1:0] KIND_VIDEO    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AUDIO    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUBTITLE = 2'd2;

    localparam logic POOL_GENERIC   = 1'b0;
    localparam logic POOL_WEB_AUDIO = 1'b1;

    localparam logic [2:0] REG_GENERIC_COUNT   = 3'd0;
    localparam logic [2:0] REG_WEB_AUDIO_COUNT = 3'd1;
    localparam logic [2:0] REG_VIDEO_BYTES     = 3'd2;
    localparam logic [2:0] REG_AUDIO_BYTES     = 3'd3;
    localparam logic [2:0] REG_SUBTITLE_BYTES  = 3'd4;
    localparam logic [2:0] REG_WEB_AUDIO_BYTES = 3'd5;

    localparam logic [BYTES_W-1:0] VIDEO_BYTES_RST     = BYTES_W'(7 * 1024 * 1024);
    localparam logic [BYTES_W-1:0] AUDIO_BYTES_RST     = BYTES_W'(1 * 1024 * 1024);
    localparam logic [BYTES_W-1:0] SUBTITLE_BYTES_RST  = BYTES_W'(256 * 1024);
    localparam logic [BYTES_W-1:0] WEB_AUDIO_BYTES_RST = BYTES_W'(10 * 1024);
    localparam logic [GSIZE_W-1:0] GSIZE_RST =
        GSIZE_W'(7 * 1024 * 1024 + 1 * 1024 * 1024 + 256 * 1024);
    localparam logic [VA_W-1:0]    VA_RST    = VA_W'(7 * 1024 * 1024 + 1 * 1024 * 1024);

    typedef struct packed {
        logic [COUNT_W-1:0]  generic_count;
        logic [COUNT_W-1:0]  web_audio_count;
        logic [BYTES_W-1:0]  video_bytes;
        logic [BYTES_W-1:0]  audio_bytes;
        logic [BYTES_W-1:0]  subtitle_bytes;
        logic [BYTES_W-1:0]  web_audio_bytes;
        logic [GSIZE_W-1:0]  generic_size;
        logic [VA_W-1:0]     video_audio_bytes;
        logic [OFFSET_W-1:0] generic_span;
    } t_cfg;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
    } t_lookup;

    typedef struct packed {
        logic map;
        logic unmap;
    } t_update;

endpackage

FILE: design/pst_in_if.sv
`timescale 1ns / 1ps

interface pst_in_if import pst_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic              pool;
    logic [ID_W-1:0]   client_id;
    logic [KIND_W-1:0] media_kind;

    modport source (output valid, command, pool, client_id, media_kind, input ready);
    modport sink   (input valid, command, pool, client_id, media_kind, output ready);

endinterface

FILE: design/pst_out_if.sv
`timescale 1ns / 1ps

interface pst_out_if import pst_pkg::*; ();

    logic                valid;
    logic                ready;
    logic                ok;
    logic [OFFSET_W-1:0] region_offset;
    logic [LEN_W-1:0]    region_length;

    modport source (output valid, ok, region_offset, region_length, input ready);
    modport sink   (input valid, ok, region_offset, region_length, output ready);

endinterface

FILE: design/pst_cfg.sv
`timescale 1ns / 1ps

module pst_cfg import pst_pkg::*; #(
    parameter int MAX_GENERIC_SLOTS = GENERIC_SLOTS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg               r_cfg;
    t_cfg               n_cfg;
    logic               wr_en;
    logic [2:0]         reg_idx;
    logic [COUNT_W-1:0] gen_count_sat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_GENERIC_COUNT:   n_cfg.generic_count   = pwdata[COUNT_W-1:0];
                REG_WEB_AUDIO_COUNT: n_cfg.web_audio_count = pwdata[COUNT_W-1:0];
                REG_VIDEO_BYTES:     n_cfg.video_bytes     = pwdata[BYTES_W-1:0];
                REG_AUDIO_BYTES:     n_cfg.audio_bytes     = pwdata[BYTES_W-1:0];
                REG_SUBTITLE_BYTES:  n_cfg.subtitle_bytes  = pwdata[BYTES_W-1:0];
                REG_WEB_AUDIO_BYTES: n_cfg.web_audio_bytes = pwdata[BYTES_W-1:0];
                default: ;
            endcase
        end
        // derived sizes follow the written values
        n_cfg.generic_size = GSIZE_W'(n_cfg.video_bytes) + GSIZE_W'(n_cfg.audio_bytes)
                           + GSIZE_W'(n_cfg.subtitle_bytes);
        n_cfg.video_audio_bytes = VA_W'(n_cfg.video_bytes) + VA_W'(n_cfg.audio_bytes);
        gen_count_sat = (32'(n_cfg.generic_count) > MAX_GENERIC_SLOTS)
                      ? COUNT_W'(MAX_GENERIC_SLOTS) : n_cfg.generic_count;
        n_cfg.generic_span = OFFSET_W'(gen_count_sat) * OFFSET_W'(n_cfg.generic_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.generic_count     <= '0;
            r_cfg.web_audio_count   <= '0;
            r_cfg.video_bytes       <= VIDEO_BYTES_RST;
            r_cfg.audio_bytes       <= AUDIO_BYTES_RST;
            r_cfg.subtitle_bytes    <= SUBTITLE_BYTES_RST;
            r_cfg.web_audio_bytes   <= WEB_AUDIO_BYTES_RST;
            r_cfg.generic_size      <= GSIZE_RST;
            r_cfg.video_audio_bytes <= VA_RST;
            r_cfg.generic_span      <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GENERIC_COUNT:   prdata = APB_DATA_W'(r_cfg.generic_count);
            REG_WEB_AUDIO_COUNT: prdata = APB_DATA_W'(r_cfg.web_audio_count);
            REG_VIDEO_BYTES:     prdata = APB_DATA_W'(r_cfg.video_bytes);
            REG_AUDIO_BYTES:     prdata = APB_DATA_W'(r_cfg.audio_bytes);
            REG_SUBTITLE_BYTES:  prdata = APB_DATA_W'(r_cfg.subtitle_bytes);
            REG_WEB_AUDIO_BYTES: prdata = APB_DATA_W'(r_cfg.web_audio_bytes);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/pst_pool.sv
`timescale 1ns / 1ps

module pst_pool import pst_pkg::*; #(
    parameter int SLOTS = GENERIC_SLOTS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [COUNT_W-1:0] i_count,
    input  logic [ID_W-1:0]    i_id,
    input  t_update            i_upd,
    output t_lookup            o_lookup
);

    logic [ID_W-1:0]  r_owner [SLOTS];
    logic [SLOTS-1:0] r_taken;
    logic [SLOTS-1:0] n_taken;
    logic [SLOTS-1:0] hit_first;
    logic [SLOTS-1:0] free_first;
    logic             found_hit;
    logic             found_free;
    logic [IDX_W-1:0] hit_idx;

    // lowest matching and lowest free slot among the active ones
    always_comb begin
        found_hit  = 1'b0;
        found_free = 1'b0;
        hit_first  = '0;
        free_first = '0;
        hit_idx    = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (k < int'(i_count)) begin
                if (r_taken[k] && (r_owner[k] == i_id) && !found_hit) begin
                    hit_first[k] = 1'b1;
                    found_hit    = 1'b1;
                    hit_idx      = IDX_W'(k);
                end
                if (!r_taken[k] && !found_free) begin
                    free_first[k] = 1'b1;
                    found_free    = 1'b1;
                end
            end
        end
    end

    assign o_lookup.hit     = found_hit;
    assign o_lookup.hit_idx = hit_idx;
    assign o_lookup.free    = found_free;

    always_comb begin
        n_taken = r_taken;
        if (i_upd.map) begin
            n_taken = n_taken | free_first;
        end
        if (i_upd.unmap) begin
            n_taken = n_taken & ~hit_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else begin
            r_taken <= n_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SLOTS; k++) begin
            if (i_upd.map && free_first[k]) begin
                r_owner[k] <= i_id;
            end
        end
    end

endmodule

FILE: design/pst_region.sv
`timescale 1ns / 1ps

module pst_region import pst_pkg::*; (
    input  t_cfg                i_cfg,
    input  logic                i_pool,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [IDX_W-1:0]    i_idx,
    output logic [BYTES_W-1:0]  o_len,
    output logic [OFFSET_W-1:0] o_offset
);

    localparam int PROD_W = IDX_W + GSIZE_W;

    logic [GSIZE_W-1:0]  stride;
    logic [PROD_W-1:0]   prod;
    logic [OFFSET_W-1:0] base;
    logic [VA_W-1:0]     part_off;

    always_comb begin
        o_len = '0;
        if (i_pool == POOL_WEB_AUDIO) begin
            if (i_kind == KIND_AUDIO) begin
                o_len = i_cfg.web_audio_bytes;
            end
        end else begin
            case (i_kind)
                KIND_VIDEO:    o_len = i_cfg.video_bytes;
                KIND_AUDIO:    o_len = i_cfg.audio_bytes;
                KIND_SUBTITLE: o_len = i_cfg.subtitle_bytes;
                default:       o_len = '0;
            endcase
        end
    end

    always_comb begin
        part_off = '0;
        if (i_pool == POOL_WEB_AUDIO) begin
            stride = GSIZE_W'(i_cfg.web_audio_bytes);
            base   = i_cfg.generic_span;
        end else begin
            stride = i_cfg.generic_size;
            base   = '0;
            case (i_kind)
                KIND_AUDIO:    part_off = VA_W'(i_cfg.video_bytes);
                KIND_SUBTITLE: part_off = i_cfg.video_audio_bytes;
                default:       part_off = '0;
            endcase
        end
    end

    assign prod     = PROD_W'(i_idx) * PROD_W'(stride);
    assign o_offset = base + OFFSET_W'(prod) + OFFSET_W'(part_off);

endmodule

FILE: design/partition_slot_table.sv
`timescale 1ns / 1ps

// Partition slot table: maps client ids onto fixed-size partitions of one shared buffer,
// generic partitions (video, audio, subtitle regions) first, then web-audio partitions.
// One command is taken every clock cycle while results are taken; each result passes through
// the input register, then the result register, and waits there until taken, the slot search
// being a parallel compare across the pool's slots. Commands see the table as left by all
// earlier ones. The user sets region sizes and partition counts over the APB port while no
// command is in flight; the block itself does not enforce this.

module partition_slot_table import pst_pkg::*; #(
    parameter int MAX_GENERIC_SLOTS   = GENERIC_SLOTS_DEFAULT,
    parameter int MAX_WEB_AUDIO_SLOTS = WEB_AUDIO_SLOTS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pst_in_if.sink                i_cmd,
    pst_out_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg                cfg;
    logic                r_in_valid;
    t_cmd                r_cmd;
    logic                r_pool;
    logic [ID_W-1:0]     r_id;
    logic [KIND_W-1:0]   r_kind;
    logic                advance;
    t_lookup             gen_lookup;
    t_lookup             web_lookup;
    t_lookup             sel_lookup;
    t_update             gen_upd;
    t_update             web_upd;
    logic                do_map;
    logic                do_unmap;
    logic [BYTES_W-1:0]  rlen;
    logic [OFFSET_W-1:0] roffset;
    logic                r_out_valid;
    logic                r_ok;
    logic [OFFSET_W-1:0] r_off;
    logic [LEN_W-1:0]    r_len;
    logic                n_ok;
    logic [OFFSET_W-1:0] n_off;
    logic [LEN_W-1:0]    n_len;

    pst_cfg #(
        .MAX_GENERIC_SLOTS (MAX_GENERIC_SLOTS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd  <= t_cmd'(i_cmd.command);
            r_pool <= i_cmd.pool;
            r_id   <= i_cmd.client_id;
            r_kind <= i_cmd.media_kind;
        end
    end

    assign sel_lookup = (r_pool == POOL_WEB_AUDIO) ? web_lookup : gen_lookup;
    assign do_map     = advance && (r_cmd == CMD_MAP) && !sel_lookup.hit && sel_lookup.free;
    assign do_unmap   = advance && (r_cmd == CMD_UNMAP) && sel_lookup.hit;

    assign gen_upd.map   = do_map && (r_pool == POOL_GENERIC);
    assign gen_upd.unmap = do_unmap && (r_pool == POOL_GENERIC);
    assign web_upd.map   = do_map && (r_pool == POOL_WEB_AUDIO);
    assign web_upd.unmap = do_unmap && (r_pool == POOL_WEB_AUDIO);

    pst_pool #(
        .SLOTS (MAX_GENERIC_SLOTS)
    ) u_gen_pool (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_count  (cfg.generic_count),
        .i_id     (r_id),
        .i_upd    (gen_upd),
        .o_lookup (gen_lookup)
    );

    pst_pool #(
        .SLOTS (MAX_WEB_AUDIO_SLOTS)
    ) u_web_pool (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_count  (cfg.web_audio_count),
        .i_id     (r_id),
        .i_upd    (web_upd),
        .o_lookup (web_lookup)
    );

    pst_region u_region (
        .i_cfg    (cfg),
        .i_pool   (r_pool),
        .i_kind   (r_kind),
        .i_idx    (sel_lookup.hit_idx),
        .o_len    (rlen),
        .o_offset (roffset)
    );

    always_comb begin
        n_ok  = 1'b0;
        n_off = '0;
        n_len = '0;
        case (r_cmd)
            CMD_MAP:   n_ok = sel_lookup.hit || sel_lookup.free;
            CMD_UNMAP: n_ok = sel_lookup.hit;
            CMD_OFFSET: begin
                if (sel_lookup.hit && (rlen != '0)) begin
                    n_ok  = 1'b1;
                    n_off = roffset;
                end
            end
            CMD_LENGTH: begin
                if (sel_lookup.hit) begin
                    n_ok  = 1'b1;
                    n_len = LEN_W'(rlen);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_ok  <= n_ok;
            r_off <= n_off;
            r_len <= n_len;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.ok            = r_ok;
    assign o_rsp.region_offset = r_off;
    assign o_rsp.region_length = r_len;

endmodule
